FILE: hdl/sac_pkg.sv
// Package for the set-associative cache model: word types, config register
// indexes and the lookup status bundle. No dependencies.
package sac_pkg;

    // Input word: one cache access
    typedef struct packed {
        logic        is_write;
        logic [31:0] address;
    } in_word_t;

    // Result word: access outcome and running totals after this access
    typedef struct packed {
        logic        hit;
        logic        mem_read;
        logic        mem_write;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] read_total;
        logic [31:0] write_total;
    } out_word_t;

    // Config port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 4;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

    localparam cfg_index_t CFG_OFFSET_BITS    = 2'd0;
    localparam cfg_index_t CFG_SET_INDEX_BITS = 2'd1;
    localparam cfg_index_t CFG_WAYS_IN_USE    = 2'd2;

    localparam cfg_data_t OFFSET_BITS_RST    = 4'd0;
    localparam cfg_data_t SET_INDEX_BITS_RST = 4'd0;
    localparam cfg_data_t WAYS_IN_USE_RST    = 4'd1;

    // Lookup status handed from the lookup logic to the pipeline
    typedef struct packed {
        logic hit;
        logic row_we;
    } look_stat_t;

endpackage

FILE: hdl/sac_row_ram.sv
// Set memory: one row per set holding all way tags plus fill and FIFO state.
// One write port, one read port with registered read data. No dependencies.
module sac_row_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 263
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, read-before-write on a shared address
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/sac_lookup.sv
// Tag compare and FIFO replacement for one set row.
// Depends on sac_pkg (look_stat_t).
module sac_lookup #(
    parameter int MAX_WAYS = 8,
    parameter int AW       = 32
) (
    input  logic [MAX_WAYS*AW + $clog2(MAX_WAYS+1) + (MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0]
                                              row_i,
    input  logic [AW-1:0]                     blk_i,
    input  logic [$clog2(MAX_WAYS+1)-1:0]     ways_i,
    output logic [MAX_WAYS*AW + $clog2(MAX_WAYS+1) + (MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0]
                                              row_o,
    output sac_pkg::look_stat_t               stat_o
);

    localparam int FILL_W   = $clog2(MAX_WAYS + 1);
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int TAG_BITS = MAX_WAYS * AW;

    logic [FILL_W-1:0] fill;
    logic [WAY_W-1:0]  oldest;
    logic [WAY_W-1:0]  victim;
    logic [FILL_W-1:0] fill_new;
    logic [WAY_W-1:0]  oldest_new;
    logic [FILL_W-1:0] victim_inc;
    logic              hit;

    assign fill   = row_i[TAG_BITS +: FILL_W];
    assign oldest = row_i[TAG_BITS + FILL_W +: WAY_W];

    // search the valid ways in use; ways below the fill count are valid
    always_comb begin
        hit = 1'b0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if ((FILL_W'(w) < ways_i) && (FILL_W'(w) < fill) &&
                (row_i[w*AW +: AW] == blk_i)) begin
                hit = 1'b1;
            end
        end
    end

    // victim choice: next empty way, else oldest way round robin
    always_comb begin
        fill_new   = fill;
        oldest_new = oldest;
        victim_inc = '0;
        if (fill < ways_i) begin
            victim   = WAY_W'(fill);
            fill_new = fill + FILL_W'(1);
        end else begin
            victim     = (FILL_W'(oldest) >= ways_i) ? '0 : oldest;
            victim_inc = FILL_W'(victim) + FILL_W'(1);
            oldest_new = (victim_inc == ways_i) ? '0 : WAY_W'(victim_inc);
        end
    end

    // updated row for a miss
    always_comb begin
        row_o = row_i;
        if (!hit) begin
            for (int w = 0; w < MAX_WAYS; w++) begin
                if (WAY_W'(w) == victim) begin
                    row_o[w*AW +: AW] = blk_i;
                end
            end
            row_o[TAG_BITS +: FILL_W]         = fill_new;
            row_o[TAG_BITS + FILL_W +: WAY_W] = oldest_new;
        end
    end

    assign stat_o.hit    = hit;
    assign stat_o.row_we = !hit;

endmodule

FILE: hdl/set_assoc_cache_fifo_sim.sv
// Top level of the set-associative cache model with FIFO replacement.
// Depends on sac_pkg, sac_row_ram and sac_lookup.
//
//  channel | ports                        | direction | word
//  --------+------------------------------+-----------+-------------------
//  access  | s_valid s_ready s_data       | in        | sac_pkg::in_word_t
//  result  | m_valid m_ready m_data       | out       | sac_pkg::out_word_t
//  config  | cfg_valid cfg_ready cfg_index cfg_data | in | 4-bit register
//
// One access per cycle sustained while the result channel is not stalled; a
// result becomes valid once its access word has passed the compare stage (set
// memory read at the accepting edge, compare/update in the compare stage).
// After reset a clearing pass zeroes the fill and FIFO state of every set;
// s_ready stays low meanwhile. Config is always ready.
// A stalled result holds the compare stage; a write to the set being read
// is forwarded to the next access.
module set_assoc_cache_fifo_sim #(
    parameter int MAX_SETS   = 256,
    parameter int MAX_WAYS   = 8,
    parameter int ADDR_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // access channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sac_pkg::in_word_t    s_data,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output sac_pkg::out_word_t   m_data,
    // config channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  sac_pkg::cfg_index_t  cfg_index,
    input  sac_pkg::cfg_data_t   cfg_data
);

    localparam int AW       = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;
    localparam int SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int SIB_MAX  = $clog2(MAX_SETS + 1) - 1;
    localparam int FILL_W   = $clog2(MAX_WAYS + 1);
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int ROW_W    = MAX_WAYS * AW + FILL_W + WAY_W;
    localparam int CW       = (FILL_W > 4) ? FILL_W : 4;

    // config registers
    sac_pkg::cfg_data_t offset_bits_reg;
    sac_pkg::cfg_data_t set_index_bits_reg;
    sac_pkg::cfg_data_t ways_in_use_reg;

    // clearing pass
    logic             clr_active_reg;
    logic [SET_W-1:0] clr_addr_reg;

    // compare stage
    logic             v1_reg;
    logic             wr1_reg;
    logic [AW-1:0]    blk1_reg;
    logic [SET_W-1:0] set1_reg;

    // forwarding of a row written while it was being read
    logic             byp_reg;
    logic [ROW_W-1:0] byp_row_reg;

    // totals
    logic [31:0] hit_total_reg,   hit_total_next;
    logic [31:0] miss_total_reg,  miss_total_next;
    logic [31:0] read_total_reg,  read_total_next;
    logic [31:0] write_total_reg, write_total_next;

    // result register
    logic                out_valid_reg;
    sac_pkg::out_word_t  out_data_reg;

    logic                accept;
    logic                adv;
    logic [3:0]          sib_eff;
    logic [CW-1:0]       ways_ext;
    logic [FILL_W-1:0]   ways_eff;
    logic [AW-1:0]       rd_blk;
    logic [AW-1:0]       set_mask;
    logic [SET_W-1:0]    rd_set;
    logic [ROW_W-1:0]    ram_rdata;
    logic [ROW_W-1:0]    row_cur;
    logic [ROW_W-1:0]    row_new;
    logic                ram_we;
    logic [SET_W-1:0]    ram_waddr;
    logic [ROW_W-1:0]    ram_wdata;
    logic                upd_we;
    sac_pkg::look_stat_t stat;

    assign cfg_ready = 1'b1;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_bits_reg    <= sac_pkg::OFFSET_BITS_RST;
            set_index_bits_reg <= sac_pkg::SET_INDEX_BITS_RST;
            ways_in_use_reg    <= sac_pkg::WAYS_IN_USE_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                sac_pkg::CFG_OFFSET_BITS:    offset_bits_reg    <= cfg_data;
                sac_pkg::CFG_SET_INDEX_BITS: set_index_bits_reg <= cfg_data;
                sac_pkg::CFG_WAYS_IN_USE:    ways_in_use_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective set bits and way count
    always_comb begin
        sib_eff = ({1'b0, set_index_bits_reg} > 5'(SIB_MAX)) ? 4'(SIB_MAX)
                                                           : set_index_bits_reg;
        ways_ext = CW'(ways_in_use_reg);
        if (ways_in_use_reg == '0) begin
            ways_eff = FILL_W'(1);
        end else if (ways_ext > CW'(MAX_WAYS)) begin
            ways_eff = FILL_W'(MAX_WAYS);
        end else begin
            ways_eff = FILL_W'(ways_ext);
        end
    end

    // handshake
    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = !clr_active_reg && (!v1_reg || adv);
    assign accept  = s_valid && s_ready;

    // block address and set of the incoming access
    assign rd_blk   = s_data.address[AW-1:0] >> offset_bits_reg;
    assign set_mask = ~({AW{1'b1}} << sib_eff);
    assign rd_set   = SET_W'(rd_blk & set_mask);

    // clearing pass sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            if (clr_addr_reg == SET_W'(MAX_SETS - 1)) begin
                clr_active_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + SET_W'(1);
        end
    end

    // set memory write port: clearing pass or miss fill
    assign upd_we    = v1_reg && adv && stat.row_we;
    assign ram_we    = clr_active_reg || upd_we;
    assign ram_waddr = clr_active_reg ? clr_addr_reg : set1_reg;
    assign ram_wdata = clr_active_reg ? '0 : row_new;

    sac_row_ram #(
        .DEPTH (MAX_SETS),
        .WIDTH (ROW_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (rd_set),
        .rdata (ram_rdata)
    );

    // compare stage registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            byp_reg <= 1'b0;
        end else begin
            if (accept) begin
                v1_reg  <= 1'b1;
                byp_reg <= upd_we && (set1_reg == rd_set);
            end else if (adv) begin
                v1_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            wr1_reg     <= s_data.is_write;
            blk1_reg    <= rd_blk;
            set1_reg    <= rd_set;
            byp_row_reg <= row_new;
        end
    end

    assign row_cur = byp_reg ? byp_row_reg : ram_rdata;

    sac_lookup #(
        .MAX_WAYS (MAX_WAYS),
        .AW       (AW)
    ) u_lookup (
        .row_i  (row_cur),
        .blk_i  (blk1_reg),
        .ways_i (ways_eff),
        .row_o  (row_new),
        .stat_o (stat)
    );

    // running totals
    always_comb begin
        hit_total_next   = hit_total_reg   + (stat.hit ? 32'd1 : 32'd0);
        miss_total_next  = miss_total_reg  + (stat.hit ? 32'd0 : 32'd1);
        read_total_next  = read_total_reg  + (stat.hit ? 32'd0 : 32'd1);
        write_total_next = write_total_reg + (wr1_reg  ? 32'd1 : 32'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_total_reg   <= '0;
            miss_total_reg  <= '0;
            read_total_reg  <= '0;
            write_total_reg <= '0;
        end else if (v1_reg && adv) begin
            hit_total_reg   <= hit_total_next;
            miss_total_reg  <= miss_total_next;
            read_total_reg  <= read_total_next;
            write_total_reg <= write_total_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (v1_reg && adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (v1_reg && adv) begin
            out_data_reg.hit         <= stat.hit;
            out_data_reg.mem_read    <= !stat.hit;
            out_data_reg.mem_write   <= wr1_reg;
            out_data_reg.hit_total   <= hit_total_next;
            out_data_reg.miss_total  <= miss_total_next;
            out_data_reg.read_total  <= read_total_next;
            out_data_reg.write_total <= write_total_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

FILE: hdl/sac_checker.sv
// Port-level checks for the cache model, bound to the top level.
// Depends on sac_pkg and set_assoc_cache_fifo_sim.
module sac_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input sac_pkg::out_word_t  m_data
);

    // a held result word does not change
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result word changed while stalled");

    // every miss fetches, so the two totals move together
    a_miss_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.miss_total == m_data.read_total))
        else $error("miss and read totals differ");

    // a result is either a hit or a fetch, never both
    a_hit_xor_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.hit != m_data.mem_read))
        else $error("hit and mem_read flags disagree");

    // right after reset: clearing pass running, no result pending
    a_reset_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> (!s_ready && !m_valid))
        else $error("block active right after reset");

endmodule

bind set_assoc_cache_fifo_sim sac_checker u_sac_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench for set_assoc_cache_fifo_sim: drives cache access words, predicts
// hit/miss and running totals with its own FIFO-replacement cache copy.
// Depends on sac_pkg and the set_assoc_cache_fifo_sim RTL.
module tb_top;

    localparam int SETS        = 256;
    localparam int WAYS        = 8;
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 200;
    localparam int CYCLE_LIMIT = 300000;

    // Per-phase config for the random phases
    localparam int unsigned PHASE_OFF  [PHASES] = '{4, 0, 12, 6, 15, 2, 0, 0, 5};
    localparam int unsigned PHASE_SETS [PHASES] = '{2, 0, 8, 3, 15, 1, 8, 0, 0};
    localparam int unsigned PHASE_WAYS [PHASES] = '{2, 8, 1, 4, 9, 3, 8, 0, 0};

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    sac_pkg::in_word_t    s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    sac_pkg::out_word_t   m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    sac_pkg::cfg_index_t  cfg_index = sac_pkg::CFG_OFFSET_BITS;
    sac_pkg::cfg_data_t   cfg_data  = '0;

    // Pending access words and predicted outcomes
    sac_pkg::in_word_t    access_q[$];
    sac_pkg::out_word_t   outcome_q[$];

    // Predictor copy of the config registers and cache state
    sac_pkg::cfg_data_t   reg_off  = sac_pkg::OFFSET_BITS_RST;
    sac_pkg::cfg_data_t   reg_sets = sac_pkg::SET_INDEX_BITS_RST;
    sac_pkg::cfg_data_t   reg_ways = sac_pkg::WAYS_IN_USE_RST;
    logic [31:0] tag_store [SETS*WAYS];
    logic        line_ok   [SETS*WAYS];
    logic [3:0]  fill_cnt  [SETS];
    logic [2:0]  fifo_head [SETS];
    logic [31:0] hit_cnt   = '0;
    logic [31:0] miss_cnt  = '0;
    logic [31:0] rd_cnt    = '0;
    logic [31:0] wr_cnt    = '0;

    int          send_idle = 31;
    int          recv_idle = 53;
    int          errors    = 0;
    int          cycle_count = 0;

    set_assoc_cache_fifo_sim dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Look up one access, fill on a miss, and return the outcome word
    function automatic sac_pkg::out_word_t lookup_and_fill(sac_pkg::in_word_t acc);
        sac_pkg::out_word_t res;
        int unsigned sib;
        int unsigned nways;
        int unsigned set_no;
        int unsigned base_no;
        int unsigned victim;
        int unsigned w;
        logic [31:0] blk;
        logic        found;
        sib = 32'(reg_sets);
        while (sib > 0 && (1 << sib) > SETS) sib--;
        nways = 32'(reg_ways);
        if (nways == 0) nways = 1;
        if (nways > WAYS) nways = WAYS;
        blk     = acc.address >> reg_off;
        set_no  = blk & ((32'd1 << sib) - 32'd1);
        base_no = set_no * WAYS;
        found   = 1'b0;
        for (w = 0; w < nways && !found; w++) begin
            if (line_ok[base_no + w] && tag_store[base_no + w] == blk) found = 1'b1;
        end
        if (acc.is_write) wr_cnt++;
        if (found) begin
            hit_cnt++;
        end else begin
            miss_cnt++;
            rd_cnt++;
            // fill an empty way first, then replace oldest round robin
            if (32'(fill_cnt[set_no]) < nways) begin
                victim = 32'(fill_cnt[set_no]);
                fill_cnt[set_no]++;
            end else begin
                victim = 32'(fifo_head[set_no]);
                if (victim >= nways) victim = 0;
                fifo_head[set_no] = 3'((victim + 1) % nways);
            end
            tag_store[base_no + victim] = blk;
            line_ok[base_no + victim]   = 1'b1;
        end
        res.hit         = found;
        res.mem_read    = !found;
        res.mem_write   = acc.is_write;
        res.hit_total   = hit_cnt;
        res.miss_total  = miss_cnt;
        res.read_total  = rd_cnt;
        res.write_total = wr_cnt;
        return res;
    endfunction

    function automatic void check_field(string fname, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want_v, got_v);
            errors++;
        end
    endfunction

    // Driver: present queued access words, idle at random
    always @(posedge aclk) begin : drive_access
        logic taken;
        taken = aresetn && s_valid && s_ready;
        if (taken) outcome_q.push_back(lookup_and_fill(s_data));
        if (taken || !s_valid) begin
            if (aresetn && access_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
                s_valid <= 1'b1;
                s_data  <= access_q.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result word with the oldest prediction
    always @(posedge aclk) begin : check_result
        sac_pkg::out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (outcome_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_data);
                errors++;
            end else begin
                want = outcome_q.pop_front();
                check_field("hit",         32'(want.hit),       32'(m_data.hit));
                check_field("mem_read",    32'(want.mem_read),  32'(m_data.mem_read));
                check_field("mem_write",   32'(want.mem_write), 32'(m_data.mem_write));
                check_field("hit_total",   want.hit_total,   m_data.hit_total);
                check_field("miss_total",  want.miss_total,  m_data.miss_total);
                check_field("read_total",  want.read_total,  m_data.read_total);
                check_field("write_total", want.write_total, m_data.write_total);
            end
        end
        m_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // Config write, only called while the cache is idle
    task automatic write_reg(sac_pkg::cfg_index_t idx, sac_pkg::cfg_data_t val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            sac_pkg::CFG_OFFSET_BITS:    reg_off  = val;
            sac_pkg::CFG_SET_INDEX_BITS: reg_sets = val;
            sac_pkg::CFG_WAYS_IN_USE:    reg_ways = val;
            default: ;
        endcase
    endtask

    task automatic set_config(sac_pkg::cfg_data_t off, sac_pkg::cfg_data_t sets,
                              sac_pkg::cfg_data_t nways);
        write_reg(sac_pkg::CFG_OFFSET_BITS, off);
        write_reg(sac_pkg::CFG_SET_INDEX_BITS, sets);
        write_reg(sac_pkg::CFG_WAYS_IN_USE, nways);
    endtask

    task automatic push_access(logic wr, logic [31:0] addr);
        sac_pkg::in_word_t acc;
        acc.is_write = wr;
        acc.address  = addr;
        access_q.push_back(acc);
    endtask

    // Wait until every queued word is taken and every result is back
    task automatic wait_drained();
        do @(negedge aclk);
        while (access_q.size() != 0 || s_valid || outcome_q.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    // Run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Stimulus sequence
    initial begin : stimulus
        logic [31:0] pool [24];
        logic [31:0] blk;
        logic [31:0] addr;
        int          pool_n;
        int          p;
        int          i;
        int          k;

        for (i = 0; i < SETS * WAYS; i++) begin
            tag_store[i] = '0;
            line_ok[i]   = 1'b0;
        end
        for (i = 0; i < SETS; i++) begin
            fill_cnt[i]  = '0;
            fifo_head[i] = '0;
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset config, direct mapped single line
        set_config(sac_pkg::OFFSET_BITS_RST, sac_pkg::SET_INDEX_BITS_RST,
                   sac_pkg::WAYS_IN_USE_RST);
        push_access(1'b0, 32'h0000_0000);
        push_access(1'b1, 32'h0000_0000);
        push_access(1'b0, 32'hFFFF_FFFF);
        push_access(1'b1, 32'h8000_0000);
        wait_drained();

        // Large offset, set bits clamped, full set then FIFO eviction
        set_config(4'd15, 4'd15, 4'd8);
        for (k = 1; k <= 12; k++) push_access(k[0], k << 23);
        wait_drained();

        // Shrink to three ways: set counts as full, oldest pointer wraps to 0
        write_reg(sac_pkg::CFG_WAYS_IN_USE, 4'd3);
        push_access(1'b0, 32'd12 << 23);
        push_access(1'b1, 32'd11 << 23);
        push_access(1'b0, 32'd13 << 23);
        push_access(1'b1, 32'd1 << 23);
        wait_drained();

        // Zero ways acts as one
        set_config(4'd12, 4'd4, 4'd0);
        push_access(1'b0, 32'h0000_5000);
        push_access(1'b1, 32'h0000_5FFF);
        push_access(1'b0, 32'h0001_5000);
        wait_drained();

        // Too many ways saturates
        write_reg(sac_pkg::CFG_WAYS_IN_USE, 4'd15);
        push_access(1'b1, 32'hFFFF_F000);
        push_access(1'b0, 32'h0000_0FFF);
        wait_drained();

        // Random phases: mostly a small working set of blocks, some noise
        for (p = 0; p < PHASES; p++) begin
            if (p / 3 == 0) begin
                send_idle = 31;
                recv_idle = 53;
            end else if (p / 3 == 1) begin
                send_idle = 53;
                recv_idle = 31;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (p == 7)
                set_config(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                           4'($urandom_range(0, 15)));
            else
                set_config(4'(PHASE_OFF[p]), 4'(PHASE_SETS[p]), 4'(PHASE_WAYS[p]));
            pool_n = $urandom_range(4, 24);
            for (i = 0; i < pool_n; i++) pool[i] = ($urandom & 32'hFFFF_FF00) | $urandom_range(0, 3);
            for (i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 99) < 75) begin
                    blk  = pool[$urandom_range(0, pool_n - 1)];
                    addr = (blk << reg_off) | ($urandom & ((32'd1 << reg_off) - 32'd1));
                end else begin
                    addr = $urandom;
                end
                push_access(1'($urandom_range(0, 1)), addr);
            end
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: set_assoc_cache_fifo_sim.f
hdl/sac_pkg.sv
hdl/sac_row_ram.sv
hdl/sac_lookup.sv
hdl/set_assoc_cache_fifo_sim.sv
hdl/sac_checker.sv
dv/tb_top.sv
